// ----- hdl/anr_pkg.sv -----
// Shared types and constants for the nearest-neighbor audio resampler.
// No dependencies; imported by anr_ctrl, anr_datapath and the top level.
package anr_pkg;

    localparam int unsigned MaxResults = 40;   // results allowed per input transfer
    localparam int unsigned NresW      = 6;    // width of the per-item result counter
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CfgDataW   = 24;

    localparam logic [CfgIdxW-1:0] CfgChannels      = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgWideSamples   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgStepFixed     = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgSourceSamples = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgOutputFrames  = 3'd4;

    localparam logic [11:0] MinStep = 12'd32;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch new source sample
        logic emit;    // write one result into the output register
        logic commit;  // close out the current source sample
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cont;       // another frame may be emitted now
        logic slot_free;  // output register can take a result this cycle
        logic last_ch;    // current channel is the last of its frame
    } t_status;

endpackage

// ----- hdl/anr_ctrl.sv -----
// Sequencer for the resampler: steps frame checks and per-channel emits.
// Depends on anr_pkg (t_cmd, t_status).
module anr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  anr_pkg::t_status  i_status,
    output anr_pkg::t_cmd     o_cmd
);
    import anr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.cont) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_ch) begin
                        n_state = S_CHECK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/anr_datapath.sv -----
// Resampler datapath: config registers, position accumulator, counters,
// sample conversion and the output register. Depends on anr_pkg.
module anr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [anr_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [anr_pkg::CfgDataW-1:0]        i_cfg_data,
    input  logic [15:0]                         i_sample_in,
    input  anr_pkg::t_cmd                       i_cmd,
    output anr_pkg::t_status                    o_status,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [15:0]                  o_sample_out,
    output logic                                o_channel_index,
    output logic                                o_last_output
);
    import anr_pkg::*;

    // configuration
    logic [1:0]  r_channels;
    logic        r_wide;
    logic [11:0] r_step;
    logic [23:0] r_src;
    logic [23:0] r_frames;

    // sound state
    logic [23:0] r_recv;
    logic [23:0] r_frame;
    logic [35:0] r_acc;
    logic [15:0] r_prev;
    logic        r_fin;

    // per-item state
    logic [15:0]       r_cur;
    logic              r_final;
    logic [NresW-1:0]  r_nres;
    logic              r_j;

    // output register
    logic              r_ov;
    logic [15:0]       r_osample;
    logic              r_och;
    logic              r_olast;

    logic              two;
    logic [11:0]       step_eff;
    logic [23:0]       last_idx;
    logic [27:0]       pos;
    logic [28:0]       hi;
    logic [28:0]       hi_cl;
    logic [28:0]       idx;
    logic [28:0]       idx_cl;
    logic [NresW:0]    nres_next;
    logic              frame_owed;
    logic              is_last_frame;
    logic [15:0]       conv;
    logic [15:0]       emit_val;

    assign two      = r_channels[1];
    assign step_eff = (r_step < MinStep) ? MinStep : r_step;
    assign last_idx = (r_src == 24'd0) ? 24'd0 : r_src - 24'd1;
    assign pos      = r_acc[35:8];

    // highest source index this frame needs, clamped
    assign hi    = {1'b0, pos} + {28'd0, two};
    assign hi_cl = (hi > {5'd0, last_idx}) ? {5'd0, last_idx} : hi;

    assign idx    = {1'b0, pos} + {28'd0, r_j};
    assign idx_cl = (idx > {5'd0, last_idx}) ? {5'd0, last_idx} : idx;

    assign nres_next     = {1'b0, r_nres} + (two ? 7'd2 : 7'd1);
    assign frame_owed    = (r_frame < r_frames);
    assign is_last_frame = ({1'b0, r_frame} + 25'd1 == {1'b0, r_frames});

    assign o_status.cont = frame_owed
                         && (nres_next <= 7'(MaxResults))
                         && (r_fin || r_final || (hi_cl <= {5'd0, r_recv}));
    assign o_status.slot_free = !r_ov || !i_out_stall;
    assign o_status.last_ch   = !two || r_j;

    // 8-bit samples: recenter and move to the top byte
    assign conv = r_wide ? i_sample_in : {i_sample_in[7:0] ^ 8'h80, 8'h00};

    assign emit_val = r_fin ? r_prev
                    : ((idx_cl >= {5'd0, r_recv}) ? r_cur : r_prev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels <= 2'd1;
            r_wide     <= 1'b1;
            r_step     <= 12'd256;
            r_src      <= 24'd1;
            r_frames   <= 24'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgChannels:      r_channels <= i_cfg_data[1:0];
                CfgWideSamples:   r_wide     <= i_cfg_data[0];
                CfgStepFixed:     r_step     <= i_cfg_data[11:0];
                CfgSourceSamples: r_src      <= i_cfg_data;
                CfgOutputFrames:  r_frames   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv  <= '0;
            r_frame <= '0;
            r_acc   <= '0;
            r_prev  <= '0;
            r_fin   <= 1'b0;
            r_final <= 1'b0;
            r_nres  <= '0;
            r_j     <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_final <= (r_recv >= last_idx);
                r_nres  <= '0;
                r_j     <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_nres <= r_nres + NresW'(1);
                if (!two || r_j) begin
                    r_j     <= 1'b0;
                    r_frame <= r_frame + 24'd1;
                    r_acc   <= r_acc + {24'd0, step_eff};
                end else begin
                    r_j <= 1'b1;
                end
            end
            if (i_cmd.commit && !r_fin) begin
                r_prev <= r_cur;
                r_recv <= r_recv + 24'd1;
                r_fin  <= r_final;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= conv;
        end
        if (i_cmd.emit) begin
            r_osample <= emit_val;
            r_och     <= r_j;
            r_olast   <= is_last_frame && (!two || r_j);
        end
    end

    assign o_out_valid     = r_ov;
    assign o_sample_out    = r_osample;
    assign o_channel_index = r_och;
    assign o_last_output   = r_olast;

`ifndef SYNTHESIS
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NresW'(MaxResults))
        else $error("result count per item above limit");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ov || !i_out_stall))
        else $error("emit into an occupied output register");

    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_fin)
        else $error("finished flag dropped without reset");

    a_second_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j |-> two)
        else $error("second channel selected in mono mode");
`endif

endmodule

// ----- hdl/audio_nearest_resampler_top.sv -----
// Top level of the nearest-neighbor audio resampler.
// Depends on anr_pkg, anr_ctrl and anr_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_sample_in): one interleaved
//   source sample per transfer, 16-bit signed or 8-bit unsigned in the low byte.
//   Output channel (o_out_valid / i_out_stall / o_sample_out, o_channel_index,
//   o_last_output): one 16-bit signed resampled sample per transfer.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): register writes take
//   effect at the clock edge; write only while the block is idle.
// Sequence:
//   An input transfer is accepted, then each owed frame gets one check step
//   and one emit per channel (an emit waits while the output register is
//   full and i_out_stall is high), then a final check closes the item out.
//   Results are limited to 40 per input transfer. A new input transfer is
//   taken only once the item has closed out. o_out_valid rises after the
//   first emit has written the output register.
// Reset (synchronous, active low): counters, accumulator and the finished flag
//   clear; config returns to mono, wide samples, step 256, one source sample,
//   zero output frames.
// Stall: the output register holds its result while i_out_stall is high; the
//   sequencer waits, and o_in_stall stays high until the item's last result has
//   entered the output register and the item has closed out.
module audio_nearest_resampler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [anr_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [anr_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [15:0]                   i_sample_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [15:0]            o_sample_out,
    output logic                          o_channel_index,
    output logic                          o_last_output
);
    import anr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: accept, per-frame check, per-channel emit, close out
    anr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // accumulator, counters, sample conversion, output register
    anr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample_in     (i_sample_in),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_sample_out    (o_sample_out),
        .o_channel_index (o_channel_index),
        .o_last_output   (o_last_output)
    );

endmodule

// ----- verif/audio_nearest_resampler_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for audio_nearest_resampler_top: streams source samples,
// predicts each resampled output in place and checks every output transfer.
// Depends on anr_pkg and the RTL under hdl/.
module audio_nearest_resampler_top_tb;
    import anr_pkg::*;

    localparam int unsigned QuietLimit  = 2000;  // cycles with no transfer at all
    localparam int unsigned DrainCycles = 8;     // close-out slack after the last result
    localparam int unsigned MaxReports  = 10;

    // Index 7 decodes to no register; a write there must change nothing.
    localparam logic [CfgIdxW-1:0] CfgNoReg = 3'd7;

    typedef struct packed {
        logic [15:0] smp;
        logic        chan;
        logic        end_flag;
    } t_owed;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CfgIdxW-1:0]    i_cfg_index;
    logic [CfgDataW-1:0]   i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [15:0]           i_sample_in;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [15:0]    o_sample_out;
    logic                  o_channel_index;
    logic                  o_last_output;

    audio_nearest_resampler_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample_in     (i_sample_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample_out    (o_sample_out),
        .o_channel_index (o_channel_index),
        .o_last_output   (o_last_output)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: config registers and stream state, with
    // reset values matching the block's reset.
    // ------------------------------------------------------------------
    logic [1:0]  cfg_channels    = 2'd1;
    logic        cfg_wide        = 1'b1;
    logic [11:0] cfg_step        = 12'd256;
    logic [23:0] cfg_src_samples = 24'd1;
    logic [23:0] cfg_out_frames  = 24'd0;

    logic [23:0] rx_count    = '0;   // source samples taken in
    logic [23:0] frames_done = '0;   // output frames emitted
    logic [35:0] pos_acc     = '0;   // read position, 28.8 fixed point
    logic [15:0] prev_smp    = '0;   // last converted source sample
    logic        src_done    = 1'b0; // final source sample has arrived

    t_owed       owed_samples[$];    // outputs predicted but not yet seen
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    // Traffic shaping, in percent per cycle.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void owe(logic [15:0] value, logic chan, logic end_flag);
        t_owed w;
        w.smp      = value;
        w.chan     = chan;
        w.end_flag = end_flag;
        owed_samples.push_back(w);
    endfunction

    function automatic void advance_frame();
        frames_done = frames_done + 24'd1;
        pos_acc     = pos_acc + ((cfg_step < MinStep) ? MinStep : cfg_step);
    endfunction

    // Works out every output caused by one accepted source sample.
    task automatic resample_one(input logic [15:0] raw);
        longint unsigned nch, last_idx, k, p, hi, idx;
        logic            final_item, end_frame, blocked;
        logic [15:0]     cur;
        int unsigned     produced;
        nch      = (cfg_channels >= 2'd2) ? 2 : 1;
        last_idx = (cfg_src_samples == '0) ? 0 : cfg_src_samples - 24'd1;
        produced = 0;
        blocked  = 1'b0;
        if (src_done) begin
            // Past the end: input value ignored, owed frames repeat the last sample.
            while (frames_done < cfg_out_frames && produced + nch <= MaxResults) begin
                end_frame = ({1'b0, frames_done} + 25'd1) == {1'b0, cfg_out_frames};
                for (int j = 0; j < nch; j++)
                    owe(prev_smp, j[0], end_frame && (j == nch - 1));
                produced += nch;
                advance_frame();
            end
        end else begin
            k          = rx_count;
            final_item = (k >= last_idx);
            cur        = cfg_wide ? raw : {raw[7:0] ^ 8'h80, 8'h00};
            while (!blocked && frames_done < cfg_out_frames
                   && produced + nch <= MaxResults) begin
                p  = pos_acc >> 8;
                hi = p + nch - 1;
                if (hi > last_idx)
                    hi = last_idx;
                // Frame waits for its highest sample unless the sound just ended.
                if (!final_item && hi > k) begin
                    blocked = 1'b1;
                end else begin
                    end_frame = ({1'b0, frames_done} + 25'd1) == {1'b0, cfg_out_frames};
                    for (int j = 0; j < nch; j++) begin
                        idx = p + j;
                        if (idx > last_idx)
                            idx = last_idx;
                        owe((idx >= k) ? cur : prev_smp, j[0], end_frame && (j == nch - 1));
                    end
                    produced += nch;
                    advance_frame();
                end
            end
            prev_smp = cur;
            rx_count = rx_count + 24'd1;
            if (final_item)
                src_done = 1'b1;
        end
    endtask

    // Register write: one per clock; caller ends a group with close_cfg.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CfgChannels:      cfg_channels    = data[1:0];
            CfgWideSamples:   cfg_wide        = data[0];
            CfgStepFixed:     cfg_step        = data[11:0];
            CfgSourceSamples: cfg_src_samples = data[23:0];
            CfgOutputFrames:  cfg_out_frames  = data[23:0];
            default: ;
        endcase
    endtask

    task automatic close_cfg();
        i_cfg_we <= 1'b0;
    endtask

    // One input transfer, with a random lead-in gap per the current idle mix.
    task automatic push_source(input logic [15:0] raw);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= raw;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        resample_one(raw);
    endtask

    // Hold off the sender until every owed output has been seen.
    task automatic wait_owed_empty();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_samples.size() != 0)
            @(posedge i_clk);
    endtask

    // Idle point for register writes: nothing owed and the close-out done.
    task automatic settle_block();
        wait_owed_empty();
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Zero output frames: samples are taken in but nothing comes out.
    // Also channel count zero, step zero, and a write to an unused index.
    task automatic test_silent_output();
        write_reg(CfgSourceSamples, 24'hFFFFFF);
        write_reg(CfgOutputFrames, 24'd0);
        write_reg(CfgChannels, 24'd0);
        write_reg(CfgStepFixed, 24'd0);
        write_reg(CfgNoReg, 24'($urandom));
        close_cfg();
        push_source(16'h0000);
        push_source(16'hFFFF);
        push_source(16'h8000);
        settle_block();
    endtask

    // Mono 16-bit at unity step; the first transfer also releases the
    // frames held back while output was off (older samples come from
    // the previous-sample register).
    task automatic test_wide_mono();
        write_reg(CfgChannels, 24'd1);
        write_reg(CfgWideSamples, 24'd1);
        write_reg(CfgStepFixed, 24'd256);
        write_reg(CfgOutputFrames, 24'hFFFFFF);
        close_cfg();
        push_source(16'h7FFF);
        push_source(16'h8000);
        push_source(16'h0001);
        push_source(16'hFFFF);
        push_source(16'h0000);
        settle_block();
    endtask

    // Stereo 8-bit at 2x downsample: recentering, high byte ignored.
    task automatic test_narrow_stereo();
        write_reg(CfgChannels, 24'd2);
        write_reg(CfgWideSamples, 24'd0);
        write_reg(CfgStepFixed, 24'd512);
        close_cfg();
        push_source(16'h0000);
        push_source(16'h00FF);
        push_source(16'h0080);
        push_source(16'hAB7F);
        push_source(16'hFF01);
        settle_block();
    endtask

    // Step extremes: maximum upsample in stereo (channel count three), maximum
    // downsample in mono, then a step below the floor.
    task automatic test_step_extremes();
        write_reg(CfgChannels, 24'd3);
        write_reg(CfgWideSamples, 24'd1);
        write_reg(CfgStepFixed, 24'd32);
        close_cfg();
        repeat (3) push_source(16'($urandom));
        settle_block();
        write_reg(CfgChannels, 24'd1);
        write_reg(CfgStepFixed, 24'd4095);
        close_cfg();
        repeat (4) push_source(16'($urandom));
        settle_block();
        write_reg(CfgStepFixed, 24'd31);
        close_cfg();
        repeat (2) push_source(16'($urandom));
        settle_block();
    endtask

    // ------------------------------------------------------------------
    // Random traffic: four idle/stall mixes, a fresh random setting each.
    // The second phase caps the frame count so a backlog builds up; the
    // next phase lifts the cap and drains it at the per-transfer limit.
    // Register data carries junk in the unused upper bits.
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        logic [11:0] step;
        for (int phase = 0; phase < 4; phase++) begin
            settle_block();
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 17; sink_stall_pct = 17; end
            endcase
            case ($urandom_range(0, 3))
                0: step = 12'd32;
                1: step = 12'd4095;
                2: step = 12'($urandom_range(32, 400));
                default: step = 12'($urandom_range(0, 4095));
            endcase
            write_reg(CfgChannels, (24'($urandom) & 24'hFFFFFC) | 24'($urandom_range(0, 3)));
            write_reg(CfgWideSamples, (24'($urandom) & 24'hFFFFFE) | 24'($urandom_range(0, 1)));
            write_reg(CfgStepFixed, (24'($urandom) & 24'hFFF000) | 24'(step));
            write_reg(CfgOutputFrames, (phase == 1) ?
                      frames_done + 24'($urandom_range(5, 30)) : 24'hFFFFFF);
            close_cfg();
            for (int n = 0; n < 72; n++) begin
                // Now and then the sender waits for the output side to empty.
                if (n % 24 == 23)
                    wait_owed_empty();
                push_source(16'($urandom));
            end
        end
    endtask

    // End of sound: source count zero makes the next transfer the final one,
    // every index clamps below it and takes the previous sample. The flush
    // needs more than one transfer's worth of outputs, so the transfers after
    // it carry the rest, the last one flagged; one more transfer is ignored.
    task automatic test_final_flush();
        settle_block();
        src_idle_pct   = 17;
        sink_stall_pct = 17;
        write_reg(CfgChannels, 24'd2);
        write_reg(CfgWideSamples, 24'd1);
        write_reg(CfgStepFixed, 24'd200);
        write_reg(CfgSourceSamples, 24'd0);
        write_reg(CfgOutputFrames, frames_done + 24'd50);
        close_cfg();
        repeat (4) push_source(16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Output checker: each output transfer against the oldest owed output.
    // ------------------------------------------------------------------
    t_owed want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("%0t: output with nothing owed: sample %h ch %0d end %0b",
                             $time, o_sample_out, o_channel_index, o_last_output);
            end else begin
                want = owed_samples.pop_front();
                if (o_sample_out !== want.smp || o_channel_index !== want.chan
                    || o_last_output !== want.end_flag) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("%0t: mismatch: want %h ch %0d end %0b, got %h ch %0d end %0b",
                                 $time, want.smp, want.chan, want.end_flag,
                                 o_sample_out, o_channel_index, o_last_output);
                end
            end
        end
    end

    // Random output stall per the current mix.
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence. The block is one continuous sound from reset on, so
    // the end-of-sound test comes last.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CfgChannels;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample_in <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_silent_output();
        test_wide_mono();
        test_narrow_stereo();
        test_step_extremes();
        test_random_traffic();
        test_final_flush();

        settle_block();
        if (mismatches == 0 && owed_samples.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
